/* sv/gbca_pkg.sv */
// gbca_pkg: shared types, constants and command structs for the grid binned cell averager
// used by the controller, datapath and top level; no dependencies

package gbca_pkg;

    localparam int MAX_HEIGHTS = 16;
    localparam int MAX_WIDTHS  = 16;
    localparam int COUNT_BITS  = 16;
    localparam int WBITS       = $clog2(MAX_WIDTHS);
    localparam int HBITS       = $clog2(MAX_HEIGHTS);
    localparam int ADDR_BITS   = HBITS + 2 * WBITS;
    localparam int NCELLS      = MAX_HEIGHTS * MAX_WIDTHS * MAX_WIDTHS;
    localparam int SUM_BITS    = 48;
    localparam int CFG_BITS    = 32;
    localparam int IDX_BITS    = 3;

    localparam logic [IDX_BITS-1:0] REG_NUM_HEIGHTS  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_NUM_WIDTHS   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_HEIGHT_STEP  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_WIDTH_STEP   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_WIDTH_ORIGIN = 3'd4;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        t_ST_CLEAR, t_ST_IDLE, t_ST_BIN, t_ST_FETCH, t_ST_WAIT, t_ST_UPDATE,
        t_ST_DIV, t_ST_DONE, t_ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input transaction
        logic bin_step;  // one shift-subtract step on all three axes
        logic mem_rd;    // read cell memory at current address
        logic update;    // write back add or clear result
        logic div_init;  // start divide
        logic div_step;  // one divide step
        logic clr_wr;    // write zero at clear address
        logic result;    // latch result into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic bin_last;
        logic div_last;
        logic clr_last;
    } t_sts;

endpackage

/* sv/gbca_ctrl.sv */
// gbca_ctrl: controller state machine sequencing clear, binning, memory and divide
// depends on gbca_pkg

module gbca_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  gbca_pkg::t_sts i_sts,
    output gbca_pkg::t_cmd o_cmd
);

    gbca_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbca_pkg::t_ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            gbca_pkg::t_ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = gbca_pkg::t_ST_IDLE;
                end
            end
            gbca_pkg::t_ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = gbca_pkg::t_ST_BIN;
                end
            end
            gbca_pkg::t_ST_BIN: begin
                if (i_sts.is_read) begin
                    n_state = gbca_pkg::t_ST_FETCH;
                end else begin
                    o_cmd.bin_step = 1'b1;
                    if (i_sts.bin_last) begin
                        n_state = gbca_pkg::t_ST_FETCH;
                    end
                end
            end
            gbca_pkg::t_ST_FETCH: begin
                o_cmd.mem_rd = 1'b1;
                n_state = gbca_pkg::t_ST_WAIT;
            end
            gbca_pkg::t_ST_WAIT: begin
                if (i_sts.is_read) begin
                    o_cmd.div_init = 1'b1;
                    n_state = gbca_pkg::t_ST_DIV;
                end else begin
                    n_state = gbca_pkg::t_ST_UPDATE;
                end
            end
            gbca_pkg::t_ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = gbca_pkg::t_ST_UPDATE;
                end
            end
            gbca_pkg::t_ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = gbca_pkg::t_ST_DONE;
            end
            gbca_pkg::t_ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.result = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = gbca_pkg::t_ST_IDLE;
                end
            end
            default: n_state = gbca_pkg::t_ST_IDLE;
        endcase
    end

endmodule

/* sv/gbca_dp.sv */
// gbca_dp: datapath with config registers, shift-subtract binning, cell memories,
// restoring divider and output register; depends on gbca_pkg

module gbca_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gbca_pkg::IDX_BITS-1:0]   i_cfg_index,
    input  logic [gbca_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  logic                            i_in_op,
    input  logic [143:0]                    i_in_data,
    input  gbca_pkg::t_cmd                  i_cmd,
    output gbca_pkg::t_sts                  o_sts,
    output logic [47:0]                     o_out_data,
    output logic [1:0]                      o_out_user
);

    localparam int SB = gbca_pkg::SUM_BITS;
    localparam int CB = gbca_pkg::COUNT_BITS;
    localparam int AB = gbca_pkg::ADDR_BITS;
    // quotient bits for the axis search, covers step of one over 33-bit span
    localparam int QB = 33;
    localparam int QCB = $clog2(QB + 1);
    localparam int DCB = $clog2(SB + 1);
    localparam int CLB = $clog2(gbca_pkg::NCELLS + 1);

    // configuration registers
    logic [4:0]  r_nh, r_nw;
    logic [30:0] r_hstep, r_wstep;
    logic signed [31:0] r_worg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nh    <= 5'd16;
            r_nw    <= 5'd16;
            r_hstep <= 31'd65536;
            r_wstep <= 31'd65536;
            r_worg  <= -32'sd524288;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gbca_pkg::REG_NUM_HEIGHTS:  r_nh    <= i_cfg_data[4:0];
                gbca_pkg::REG_NUM_WIDTHS:   r_nw    <= i_cfg_data[4:0];
                gbca_pkg::REG_HEIGHT_STEP:  r_hstep <= i_cfg_data[30:0];
                gbca_pkg::REG_WIDTH_STEP:   r_wstep <= i_cfg_data[30:0];
                gbca_pkg::REG_WIDTH_ORIGIN: r_worg  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped sizes: zero taken as one, capped at the maximum
    logic [4:0] w_nh_c, w_nw_c;
    always_comb begin
        w_nh_c = (r_nh == 5'd0) ? 5'd1 :
                 (r_nh > 5'(gbca_pkg::MAX_HEIGHTS)) ? 5'(gbca_pkg::MAX_HEIGHTS) : r_nh;
        w_nw_c = (r_nw == 5'd0) ? 5'd1 :
                 (r_nw > 5'(gbca_pkg::MAX_WIDTHS)) ? 5'(gbca_pkg::MAX_WIDTHS) : r_nw;
    end
    logic [30:0] w_hs, w_ws;
    assign w_hs = (r_hstep == 31'd0) ? 31'd1 : r_hstep;
    assign w_ws = (r_wstep == 31'd0) ? 31'd1 : r_wstep;

    // captured transaction
    logic        r_op;
    logic signed [31:0] r_val;
    logic [AB-1:0] r_rcell;
    logic        r_drop;
    // per-axis remainder and quotient for shift-subtract search (x, y, z)
    logic [QB-1:0] r_rem [3];
    logic [QB-1:0] r_q   [3];
    logic [QCB-1:0] r_bcnt;

    logic signed [32:0] w_dx, w_dy, w_dz;
    assign w_dx = 33'(signed'(i_in_data[63:32]))  - 33'(r_worg);
    assign w_dy = 33'(signed'(i_in_data[95:64]))  - 33'(r_worg);
    assign w_dz = 33'(signed'(i_in_data[127:96]));

    logic [QB:0] w_trial [3];
    logic [30:0] w_div [3];
    assign w_div[0] = w_ws;
    assign w_div[1] = w_ws;
    assign w_div[2] = w_hs;

    // one restoring step per axis, numerator bits enter from the top
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_trial[a] = {r_rem[a], r_q[a][QB-1]} - {3'd0, w_div[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_op;
            r_val   <= i_in_data[31:0];
            r_rcell <= i_in_data[139:128];
            r_drop  <= w_dx[32] | w_dy[32] | w_dz[32];
            r_rem[0] <= '0;
            r_rem[1] <= '0;
            r_rem[2] <= '0;
            r_q[0]  <= w_dx;
            r_q[1]  <= w_dy;
            r_q[2]  <= w_dz;
            r_bcnt  <= '0;
        end else if (i_cmd.bin_step) begin
            for (int a = 0; a < 3; a++) begin
                if (!w_trial[a][QB]) begin
                    r_rem[a] <= w_trial[a][QB-1:0];
                    r_q[a]   <= {r_q[a][QB-2:0], 1'b1};
                end else begin
                    r_rem[a] <= {r_rem[a][QB-2:0], r_q[a][QB-1]};
                    r_q[a]   <= {r_q[a][QB-2:0], 1'b0};
                end
            end
            r_bcnt <= r_bcnt + 1'b1;
        end
    end

    // clamp axis quotients to last cell
    logic [gbca_pkg::WBITS-1:0] w_ix, w_iy;
    logic [gbca_pkg::HBITS-1:0] w_iz;
    always_comb begin
        w_ix = (r_q[0] > QB'(w_nw_c - 5'd1)) ? gbca_pkg::WBITS'(w_nw_c - 5'd1)
                                              : gbca_pkg::WBITS'(r_q[0]);
        w_iy = (r_q[1] > QB'(w_nw_c - 5'd1)) ? gbca_pkg::WBITS'(w_nw_c - 5'd1)
                                              : gbca_pkg::WBITS'(r_q[1]);
        w_iz = (r_q[2] > QB'(w_nh_c - 5'd1)) ? gbca_pkg::HBITS'(w_nh_c - 5'd1)
                                              : gbca_pkg::HBITS'(r_q[2]);
    end

    logic [AB-1:0] w_addr;
    assign w_addr = r_op ? r_rcell : {w_iz, w_iy, w_ix};

    // clearing sweep after reset
    logic [CLB-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // cell memories, one write port and one registered read port
    logic signed [SB-1:0] r_sum_mem [gbca_pkg::NCELLS];
    logic [CB-1:0]        r_cnt_mem [gbca_pkg::NCELLS];
    logic signed [SB-1:0] r_sum_rd;
    logic [CB-1:0]        r_cnt_rd;
    logic                 w_we;
    logic [AB-1:0]        w_waddr;
    logic signed [SB-1:0] w_wsum;
    logic [CB-1:0]        w_wcnt;

    logic signed [SB:0] w_add;
    assign w_add = (SB+1)'(r_sum_rd) + (SB+1)'(r_val);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr;
        w_wsum  = '0;
        w_wcnt  = '0;
        if (i_cmd.clr_wr) begin
            w_we    = 1'b1;
            w_waddr = r_clr[AB-1:0];
        end else if (i_cmd.update) begin
            if (r_op) begin
                w_we = 1'b1;
            end else if (!r_drop && (r_cnt_rd != {CB{1'b1}})) begin
                w_we   = 1'b1;
                w_wcnt = r_cnt_rd + 1'b1;
                if (w_add[SB] != w_add[SB-1]) begin
                    w_wsum = w_add[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
                end else begin
                    w_wsum = w_add[SB-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_sum_mem[w_waddr] <= w_wsum;
            r_cnt_mem[w_waddr] <= w_wcnt;
        end
        if (i_cmd.mem_rd) begin
            r_sum_rd <= r_sum_mem[w_addr];
            r_cnt_rd <= r_cnt_mem[w_addr];
        end
    end

    // restoring divider on magnitudes, one quotient bit per cycle
    logic [SB-1:0] r_dq;
    logic [CB:0]   r_drem;
    logic [DCB-1:0] r_dcnt;
    logic          r_neg;
    logic [CB+1:0] w_dtrial;
    assign w_dtrial = {r_drem, r_dq[SB-1]} - {2'd0, r_cnt_rd};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dq   <= r_sum_rd[SB-1] ? SB'(-r_sum_rd) : r_sum_rd;
            r_neg  <= r_sum_rd[SB-1];
            r_drem <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_dtrial[CB+1]) begin
                r_drem <= w_dtrial[CB:0];
                r_dq   <= {r_dq[SB-2:0], 1'b1};
            end else begin
                r_drem <= {r_drem[CB-1:0], r_dq[SB-1]};
                r_dq   <= {r_dq[SB-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // signed quotient saturated to 32 bits
    logic signed [SB:0] w_sq;
    logic signed [31:0] w_avg;
    assign w_sq = r_neg ? -(SB+1)'({1'b0, r_dq}) : (SB+1)'({1'b0, r_dq});
    always_comb begin
        if (w_sq > 49'sh7FFFFFFF) begin
            w_avg = 32'h7FFFFFFF;
        end else if (w_sq < -49'sh80000000) begin
            w_avg = 32'h80000000;
        end else begin
            w_avg = w_sq[31:0];
        end
    end

    // output register: avg and addr in data, empty and dropped in user
    logic w_empty;
    assign w_empty = (r_cnt_rd == '0);
    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            o_out_data[47:44] <= 4'd0;
            if (r_op) begin
                o_out_data[31:0]  <= w_empty ? 32'd0 : w_avg;
                o_out_data[43:32] <= r_rcell;
                o_out_user        <= {1'b0, w_empty};
            end else begin
                o_out_data[31:0]  <= 32'd0;
                o_out_data[43:32] <= r_drop ? 12'd0 : w_addr;
                o_out_user        <= {r_drop, 1'b0};
            end
        end
    end

    assign o_sts.is_read  = r_op;
    assign o_sts.bin_last = (r_bcnt == QCB'(QB - 1));
    assign o_sts.div_last = (r_dcnt == DCB'(SB - 1));
    assign o_sts.clr_last = (r_clr == CLB'(gbca_pkg::NCELLS - 1));

endmodule

/* sv/grid_binned_cell_averager.sv */
// grid_binned_cell_averager: one transaction at a time; a new transaction is accepted
// only once the previous result is in the output register, which waits while an earlier
// result is held under back-pressure; binning uses a 33-step shift-subtract search
// per axis, reads a 48-step restoring divider over the memory read port
// after reset a clearing pass over all 4096 cells zeroes the memory, no input taken meanwhile
// config writes take effect at the next edge; synchronous active-low reset

module grid_binned_cell_averager (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_value[31:0], pos_x[63:32], pos_y[95:64], pos_z[127:96], read_cell[139:128], pad
    input  logic [143:0] s_axis_tdata,
    // opcode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cell_average[31:0], cell_addr[43:32], pad
    output logic [47:0]  m_axis_tdata,
    // cell_empty[0], sample_dropped[1]
    output logic [1:0]   m_axis_tuser
);

    gbca_pkg::t_cmd w_cmd;
    gbca_pkg::t_sts w_sts;

    // controller
    gbca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath
    gbca_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_op     (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

/* sv/gbca_checker.sv */
// gbca_checker: port-level assertions for the grid binned cell averager
// depends on the top level ports only; bound below

module gbca_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [47:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed under stall");

    // an accepted transaction closes the input for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input reopened during work");

    // empty and dropped never both set
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("empty and dropped together");

    // empty result carries zero average
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("empty cell with non-zero average");

endmodule

bind grid_binned_cell_averager gbca_checker u_gbca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/grid_binned_cell_averager_tb.sv */
// grid_binned_cell_averager_tb: self-checking testbench for the grid binned cell averager
// depends on gbca_pkg and grid_binned_cell_averager; predicts each result and compares it
`timescale 1ns / 1ps

module grid_binned_cell_averager_tb;

    typedef struct {
        logic [31:0] avg;
        logic        empty;
        logic        dropped;
        logic [11:0] addr;
    } t_cell_result;

    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 70;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // sample_value, pos_x, pos_y, pos_z, read_cell, pad
    logic [143:0] s_axis_tdata = '0;
    // opcode
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // cell_average, cell_addr, pad
    logic [47:0]  m_axis_tdata;
    // cell_empty, sample_dropped
    logic [1:0]   m_axis_tuser;

    grid_binned_cell_averager DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // mirrored registers and cell store
    logic [4:0]         grid_heights;
    logic [4:0]         grid_widths;
    logic [30:0]        height_pitch;
    logic [30:0]        width_pitch;
    logic signed [31:0] width_base;
    longint             cell_sum [gbca_pkg::NCELLS];
    int unsigned        cell_cnt [gbca_pkg::NCELLS];

    t_cell_result pending_results[$];
    int  mismatches = 0;
    int  send_gap_pct = 0;
    int  recv_stall_pct = 0;
    int  idle_cycles = 0;

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checking
    always @(posedge i_clk) begin
        t_cell_result exp_r;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h %b", $realtime, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.avg || m_axis_tuser[0] !== exp_r.empty ||
                    m_axis_tuser[1] !== exp_r.dropped || m_axis_tdata[43:32] !== exp_r.addr)
                begin
                    $display("%0t: expected avg %h empty %b dropped %b addr %h, got %h %b %b %h",
                             $realtime, exp_r.avg, exp_r.empty, exp_r.dropped, exp_r.addr,
                             m_axis_tdata[31:0], m_axis_tuser[0], m_axis_tuser[1],
                             m_axis_tdata[43:32]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int clamp_cells(logic [4:0] n, int maxn);
        if (n == 0) return 1;
        return (n > maxn) ? maxn : int'(n);
    endfunction

    // cell index along one axis, -1 below the axis start
    function automatic longint axis_cell(longint coord, longint origin, longint step, int n);
        longint diff, idx;
        diff = coord - origin;
        if (step == 0) step = 1;
        if (diff < 0) return -1;
        idx = diff / step;
        return (idx > n - 1) ? n - 1 : idx;
    endfunction

    function automatic t_cell_result bin_or_read(logic op, logic signed [31:0] val,
                                                 logic signed [31:0] px, logic signed [31:0] py,
                                                 logic signed [31:0] pz, logic [11:0] rcell);
        t_cell_result r;
        longint ix, iy, iz, s, q;
        int c, nh, nw;
        r = '{avg: '0, empty: 1'b0, dropped: 1'b0, addr: '0};
        if (op == gbca_pkg::OP_ADD) begin
            nh = clamp_cells(grid_heights, gbca_pkg::MAX_HEIGHTS);
            nw = clamp_cells(grid_widths, gbca_pkg::MAX_WIDTHS);
            ix = axis_cell(px, width_base, width_pitch, nw);
            iy = axis_cell(py, width_base, width_pitch, nw);
            iz = axis_cell(pz, 0, height_pitch, nh);
            if (ix < 0 || iy < 0 || iz < 0) begin
                r.dropped = 1'b1;
            end else begin
                c = int'(iz * gbca_pkg::MAX_WIDTHS * gbca_pkg::MAX_WIDTHS
                         + iy * gbca_pkg::MAX_WIDTHS + ix);
                r.addr = c[11:0];
                if (cell_cnt[c] < (1 << gbca_pkg::COUNT_BITS) - 1) begin
                    s = cell_sum[c] + longint'(val);
                    if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
                    if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
                    cell_sum[c] = s;
                    cell_cnt[c]++;
                end
            end
        end else begin
            c = int'(rcell);
            r.addr = rcell;
            if (cell_cnt[c] != 0) begin
                q = cell_sum[c] / longint'(cell_cnt[c]);
                if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
                if (q < -64'sh8000_0000) q = -64'sh8000_0000;
                r.avg = q[31:0];
            end else begin
                r.empty = 1'b1;
            end
            cell_sum[c] = 0;
            cell_cnt[c] = 0;
        end
        return r;
    endfunction

    task automatic send_item(logic op, logic [31:0] val, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic [11:0] rcell);
        int gap;
        if ($urandom_range(99) < send_gap_pct) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, rcell, pz, py, px, val};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.insert(pending_results.size(), bin_or_read(op, val, px, py, pz, rcell));
    endtask

    // wait for every result, then for any work still in flight
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            gbca_pkg::REG_NUM_HEIGHTS:  grid_heights = value[4:0];
            gbca_pkg::REG_NUM_WIDTHS:   grid_widths  = value[4:0];
            gbca_pkg::REG_HEIGHT_STEP:  height_pitch = value[30:0];
            gbca_pkg::REG_WIDTH_STEP:   width_pitch  = value[30:0];
            gbca_pkg::REG_WIDTH_ORIGIN: width_base   = value;
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [31:0] nh, logic [31:0] nw, logic [31:0] hs, logic [31:0] ws,
                            logic [31:0] org);
        write_reg(gbca_pkg::REG_NUM_HEIGHTS, nh);
        write_reg(gbca_pkg::REG_NUM_WIDTHS, nw);
        write_reg(gbca_pkg::REG_HEIGHT_STEP, hs);
        write_reg(gbca_pkg::REG_WIDTH_STEP, ws);
        write_reg(gbca_pkg::REG_WIDTH_ORIGIN, org);
    endtask

    // coordinate mostly inside the grid, sometimes on an edge, below or anywhere
    function automatic logic [31:0] pick_coord(longint origin, longint step, int n);
        longint c;
        int r;
        if (step == 0) step = 1;
        r = $urandom_range(99);
        if (r < 8) return $urandom;
        if (r < 14) c = origin - 1 - ({$urandom, $urandom} % step);
        else if (r < 30) c = origin + longint'($urandom_range(0, n)) * step;
        else c = origin + longint'({$urandom, $urandom} % (n * step + step));
        if (c > 64'sh7FFF_FFFF || c < -64'sh8000_0000) return $urandom;
        return c[31:0];
    endfunction

    task automatic test_directed();
        logic [31:0] org;
        org = width_base;
        // lowest corner, then the furthest cell and beyond the top edge
        send_item(gbca_pkg::OP_ADD, 32'h8000_0000, org, org, 32'h0, 12'h0);
        send_item(gbca_pkg::OP_ADD, 32'h7FFF_FFFF, org, org, 32'h0, 12'h0);
        send_item(gbca_pkg::OP_READ, '0, '0, '0, '0, 12'h000);
        send_item(gbca_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  12'h0);
        send_item(gbca_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000,
                  12'h0);
        send_item(gbca_pkg::OP_READ, '0, '0, '0, '0, 12'hFFF);
        // each axis below its start drops the sample
        send_item(gbca_pkg::OP_ADD, 32'h0001_0000, org - 1, 32'h0, 32'h0, 12'h0);
        send_item(gbca_pkg::OP_ADD, 32'h0001_0000, 32'h0, org - 1, 32'h0, 12'h0);
        send_item(gbca_pkg::OP_ADD, 32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 12'h0);
        send_item(gbca_pkg::OP_ADD, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  12'h0);
        // exact edges and truncation toward zero
        send_item(gbca_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h0002_0000, 12'h0);
        send_item(gbca_pkg::OP_ADD, 32'hFFFF_FFFE, 32'h0000_FFFF, 32'h0001_FFFF, 32'h0002_FFFF,
                  12'h0);
        send_item(gbca_pkg::OP_READ, '0, '0, '0, '0, 12'h298);
        send_item(gbca_pkg::OP_READ, '0, '0, '0, '0, 12'h298);
        send_item(gbca_pkg::OP_ADD, 32'h0000_0003, 32'h0, 32'h0, 32'h0, 12'h0);
        send_item(gbca_pkg::OP_ADD, 32'h0000_0004, 32'h0, 32'h0, 32'h0, 12'h0);
        send_item(gbca_pkg::OP_READ, '0, '0, '0, '0, 12'h088);
        send_item(gbca_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  12'h555);
        drain();
    endtask

    // out-of-range sizes and zero or extreme steps and origins
    task automatic test_register_extremes();
        set_grid(0, 0, 0, 0, 32'h8000_0000);
        send_item(gbca_pkg::OP_ADD, 32'h0000_1234, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005,
                  12'h0);
        send_item(gbca_pkg::OP_ADD, 32'h0000_0001, 32'h8000_0001, 32'h8000_0000, 32'h0, 12'h0);
        send_item(gbca_pkg::OP_READ, '0, '0, '0, '0, 12'h000);
        drain();
        set_grid(31, 31, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(gbca_pkg::OP_ADD, 32'h0000_0077, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  12'h0);
        send_item(gbca_pkg::OP_ADD, 32'h0000_0078, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  12'h0);
        send_item(gbca_pkg::OP_READ, '0, '0, '0, '0, 12'h000);
        drain();
        set_grid(17, 1, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFF0);
        send_item(gbca_pkg::OP_ADD, 32'h0000_0099, 32'h0, 32'hFFFF_FFF0, 32'h0000_000F, 12'h0);
        send_item(gbca_pkg::OP_READ, '0, '0, '0, '0, 12'hF00);
        drain();
    endtask

    task automatic test_random_traffic(int count);
        logic [11:0] recent[$];
        t_cell_result r;
        int nh, nw;
        logic [11:0] rd_cell;
        for (int k = 0; k < count; k++) begin
            nh = clamp_cells(grid_heights, gbca_pkg::MAX_HEIGHTS);
            nw = clamp_cells(grid_widths, gbca_pkg::MAX_WIDTHS);
            if ($urandom_range(99) < 75) begin
                send_item(gbca_pkg::OP_ADD, $urandom,
                          pick_coord(width_base, width_pitch, nw),
                          pick_coord(width_base, width_pitch, nw),
                          pick_coord(0, height_pitch, nh), 12'($urandom));
                r = pending_results[$];
                if (!r.dropped) recent.insert(recent.size(), r.addr);
                if (recent.size() > 8) void'(recent.pop_front());
            end else begin
                if (recent.size() != 0 && $urandom_range(99) < 70)
                    rd_cell = recent[$urandom_range(recent.size() - 1)];
                else
                    rd_cell = 12'($urandom);
                send_item(gbca_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, rd_cell);
            end
        end
        drain();
    endtask

    initial begin
        grid_heights = 5'd16;
        grid_widths  = 5'd16;
        height_pitch = 31'd65536;
        width_pitch  = 31'd65536;
        width_base   = -32'sd524288;
        foreach (cell_sum[i]) begin
            cell_sum[i] = 0;
            cell_cnt[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 10;
        recv_stall_pct = 72;
        test_directed();
        test_random_traffic(420);
        test_register_extremes();

        send_gap_pct = 72;
        recv_stall_pct = 10;
        set_grid(4, 3, 32'h0000_8000, 32'h0001_8000, 32'hFFFD_0000);
        test_random_traffic(420);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_grid($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 32'h0004_0000),
                 $urandom_range(1, 32'h0004_0000), $urandom);
        test_random_traffic(460);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
